// ===== rtl/abm_pkg.sv =====
// shared constants and codes for the adjacency bit matrix
`timescale 1ns / 1ps

package abm_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int RESULT_CAP    = 16;

    localparam int REQ_W    = 3;
    localparam int NODE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int DEGREE_W = 5;
    localparam int VCOUNT_W = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_ADD_UNDIR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_DIR   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TEST      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEGREE    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LIST      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_NEIGHBOUR = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_VCOUNT = 3'd0;

endpackage

// ===== rtl/abm_row_mem.sv =====
// row storage of the edge matrix with per-row valid bits cleared at reset
`timescale 1ns / 1ps

module abm_row_mem #(
    parameter int MAX_NODES = abm_pkg::MAX_NODES_DEF,
    parameter int IDX_W     = $clog2(MAX_NODES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic [MAX_NODES-1:0] i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic [MAX_NODES-1:0] o_rdata
);

    logic [MAX_NODES-1:0] r_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_vld;
    logic [MAX_NODES-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_data & {MAX_NODES{r_rd_vld}};

endmodule

// ===== rtl/adjacency_bit_matrix.sv =====
// top level of the adjacency bit matrix: request sequencer, column scanner and register port
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high until the
// request is done. Results appear for one cycle each on o_result_valid and cannot be held
// off. The matrix rows sit in a one-port-write, one-port-read memory with a registered read,
// so timing follows memory accesses: a directed add or an edge test needs only row a, an
// undirected add or a remove does a read-modify-write of both rows, and an out-of-range
// request ends after the read of row a. Degree and neighbour listing read the row and then
// a single-bit scanner walks the columns one per cycle up to the highest set bit, with one
// neighbour result per set bit as it is reached. Unknown request types are taken and dropped
// with no result and leave busy low. The matrix is empty after reset with no clearing pass.
module adjacency_bit_matrix #(
    parameter int MAX_NODES = abm_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [abm_pkg::REQ_W-1:0]     i_req_type,
    input  logic [abm_pkg::NODE_W-1:0]    i_node_a,
    input  logic [abm_pkg::NODE_W-1:0]    i_node_b,
    output logic                          o_result_valid,
    output logic [abm_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_edge_present,
    output logic [abm_pkg::DEGREE_W-1:0]  o_degree,
    output logic [abm_pkg::NODE_W-1:0]    o_neighbour,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abm_pkg::PADDR_W-1:0]   paddr,
    input  logic [abm_pkg::PDATA_W-1:0]   pwdata,
    output logic [abm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int K_W   = $clog2(abm_pkg::RESULT_CAP);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ROW_A   = 5'b00010,
        S_FETCH_B = 5'b00100,
        S_ROW_B   = 5'b01000,
        S_SCAN    = 5'b10000
    } t_state;

    t_state                           r_state, n_state;
    logic [abm_pkg::VCOUNT_W-1:0]     r_vcount;
    logic [abm_pkg::REQ_W-1:0]        r_type;
    logic [abm_pkg::NODE_W-1:0]       r_a, r_b;
    logic                             r_bad;
    logic [MAX_NODES-1:0]             r_scan, n_scan;
    logic [IDX_W-1:0]                 r_col, n_col;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [K_W-1:0]                   r_k, n_k;

    logic                             r_out_valid, n_out_valid;
    logic [abm_pkg::STATUS_W-1:0]     r_status, n_status;
    logic                             r_edge, n_edge;
    logic [abm_pkg::DEGREE_W-1:0]     r_degree, n_degree;
    logic [abm_pkg::NODE_W-1:0]       r_nbr, n_nbr;
    logic                             r_last, n_last;

    logic                             w_accept;
    logic [CNT_W-1:0]                 w_n;
    logic [MAX_NODES-1:0]             w_col_mask;
    logic                             w_bad;
    logic                             w_we;
    logic [IDX_W-1:0]                 w_waddr, w_raddr;
    logic [MAX_NODES-1:0]             w_wdata, w_row, w_masked;
    logic [MAX_NODES-1:0]             w_bit_a, w_bit_b;
    logic                             w_bit, w_rest;
    logic                             w_is_edit;

    // effective vertex count and the mask of columns in use
    assign w_n = (int'(r_vcount) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(r_vcount);

    always_comb begin
        for (int c = 0; c < MAX_NODES; c++) begin
            w_col_mask[c] = (c < int'(w_n));
        end
    end

    assign w_accept = start && !busy;
    assign w_bad    = (int'(i_node_a) >= int'(w_n)) ||
                      ((i_req_type <= abm_pkg::REQ_TEST) && (int'(i_node_b) >= int'(w_n)));

    assign w_bit_a   = MAX_NODES'(1) << r_a;
    assign w_bit_b   = MAX_NODES'(1) << r_b;
    assign w_masked  = w_row & w_col_mask;
    assign w_bit     = r_scan[0];
    assign w_rest    = (r_scan >> 1) != '0;
    assign w_is_edit = (r_type == abm_pkg::REQ_ADD_UNDIR) || (r_type == abm_pkg::REQ_ADD_DIR) ||
                       (r_type == abm_pkg::REQ_REMOVE);

    abm_row_mem #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_row)
    );

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_valid = 1'b0;
        n_status    = abm_pkg::ST_OK;
        n_edge      = 1'b0;
        n_degree    = '0;
        n_nbr       = '0;
        n_last      = 1'b1;
        w_we        = 1'b0;
        w_waddr     = IDX_W'(r_a);
        w_wdata     = w_row | w_bit_b;
        w_raddr     = IDX_W'(r_b);

        case (r_state)
            S_IDLE: begin
                w_raddr = IDX_W'(i_node_a);
                if (w_accept && (i_req_type <= abm_pkg::REQ_LIST)) begin
                    n_state = S_ROW_A;
                end
            end
            S_ROW_A: begin
                if (r_bad) begin
                    n_out_valid = 1'b1;
                    n_status    = abm_pkg::ST_RANGE;
                    n_state     = S_IDLE;
                end else if (w_is_edit) begin
                    w_we    = 1'b1;
                    w_wdata = (r_type == abm_pkg::REQ_REMOVE) ? (w_row & ~w_bit_b)
                                                              : (w_row | w_bit_b);
                    if (r_type == abm_pkg::REQ_ADD_DIR) begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_FETCH_B;
                    end
                end else if (r_type == abm_pkg::REQ_TEST) begin
                    n_out_valid = 1'b1;
                    n_edge      = |(w_row & w_bit_b);
                    n_state     = S_IDLE;
                end else begin
                    n_scan = w_masked;
                    n_col  = '0;
                    n_cnt  = '0;
                    n_k    = '0;
                    if (w_masked == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = (r_type == abm_pkg::REQ_LIST) ? abm_pkg::ST_NO_NEIGHBOUR
                                                                    : abm_pkg::ST_OK;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_FETCH_B: begin
                n_state = S_ROW_B;
            end
            S_ROW_B: begin
                w_we        = 1'b1;
                w_waddr     = IDX_W'(r_b);
                w_wdata     = (r_type == abm_pkg::REQ_REMOVE) ? (w_row & ~w_bit_a)
                                                              : (w_row | w_bit_a);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                n_scan = r_scan >> 1;
                n_col  = r_col + 1'b1;
                n_cnt  = r_cnt + CNT_W'(w_bit);
                if (r_type == abm_pkg::REQ_DEGREE) begin
                    if (!w_rest) begin
                        n_out_valid = 1'b1;
                        n_degree    = abm_pkg::DEGREE_W'(n_cnt);
                        n_state     = S_IDLE;
                    end
                end else if (w_bit) begin
                    n_out_valid = 1'b1;
                    n_nbr       = abm_pkg::NODE_W'(r_col);
                    n_last      = !w_rest || (r_k == K_W'(abm_pkg::RESULT_CAP - 1));
                    n_k         = r_k + 1'b1;
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vcount    <= abm_pkg::VCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr == abm_pkg::ADDR_VCOUNT)) begin
                r_vcount <= pwdata[abm_pkg::VCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_req_type;
            r_a    <= i_node_a;
            r_b    <= i_node_b;
            r_bad  <= w_bad;
        end
        r_scan   <= n_scan;
        r_col    <= n_col;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_status <= n_status;
        r_edge   <= n_edge;
        r_degree <= n_degree;
        r_nbr    <= n_nbr;
        r_last   <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_status       = r_status;
    assign o_edge_present = r_edge;
    assign o_degree       = r_degree;
    assign o_neighbour    = r_nbr;
    assign o_last         = r_last;
    assign pready         = 1'b1;
    assign prdata         = abm_pkg::PDATA_W'(r_vcount);

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |-> !busy)
        else $error("final result while still busy");

    a_more_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> busy)
        else $error("partial listing result with sequencer idle");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != abm_pkg::ST_OK) |-> o_last && (o_neighbour == '0))
        else $error("error result not final or carries a neighbour");

    a_valid_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type <= abm_pkg::REQ_LIST) |=> busy && !o_result_valid)
        else $error("accepted request did not start the sequencer");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the adjacency bit matrix: directed, register and random requests
`timescale 1ns / 1ps

module tb;

    localparam int NODES        = abm_pkg::MAX_NODES_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_MAX     = 12;
    localparam int PRINT_CAP    = 50;

    localparam logic [abm_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [abm_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [abm_pkg::STATUS_W-1:0] status;
        logic                         edge_present;
        logic [abm_pkg::DEGREE_W-1:0] degree;
        logic [abm_pkg::NODE_W-1:0]   neighbour;
        logic                         last;
    } t_matrix_result;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic                         busy;
    logic [abm_pkg::REQ_W-1:0]    i_req_type = '0;
    logic [abm_pkg::NODE_W-1:0]   i_node_a   = '0;
    logic [abm_pkg::NODE_W-1:0]   i_node_b   = '0;
    logic                         o_result_valid;
    logic [abm_pkg::STATUS_W-1:0] o_status;
    logic                         o_edge_present;
    logic [abm_pkg::DEGREE_W-1:0] o_degree;
    logic [abm_pkg::NODE_W-1:0]   o_neighbour;
    logic                         o_last;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [abm_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [abm_pkg::PDATA_W-1:0]  pwdata  = '0;
    logic [abm_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    logic [NODES-1:0]             matrix_rows [NODES];
    logic [abm_pkg::VCOUNT_W-1:0] vertex_count = abm_pkg::VCOUNT_RESET;
    t_matrix_result               pending_results [$];
    t_matrix_result               head;

    int  err_count     = 0;
    int  requests_sent = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;
    bit  idle_enable   = 1'b1;

    adjacency_bit_matrix #(.MAX_NODES(NODES)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_edge_present (o_edge_present),
        .o_degree       (o_degree),
        .o_neighbour    (o_neighbour),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int active_vertices();
        return (vertex_count > NODES) ? NODES : int'(vertex_count);
    endfunction

    task automatic predict_request(input logic [abm_pkg::REQ_W-1:0] kind,
                                   input logic [abm_pkg::NODE_W-1:0] a,
                                   input logic [abm_pkg::NODE_W-1:0] b);
        int               n;
        int               hits;
        logic [NODES-1:0] mask;
        logic [NODES-1:0] row;
        t_matrix_result   r;
        n    = active_vertices();
        hits = 0;
        mask = '0;
        for (int c = 0; c < n; c++) begin
            mask[c] = 1'b1;
        end
        r      = '0;
        r.last = 1'b1;
        if (kind > abm_pkg::REQ_LIST) begin
            return;
        end
        if (a >= n || (kind <= abm_pkg::REQ_TEST && b >= n)) begin
            r.status = abm_pkg::ST_RANGE;
            pending_results.push_back(r);
            return;
        end
        row = matrix_rows[a] & mask;
        case (kind)
            abm_pkg::REQ_ADD_UNDIR: begin
                matrix_rows[a][b] = 1'b1;
                matrix_rows[b][a] = 1'b1;
                pending_results.push_back(r);
            end
            abm_pkg::REQ_ADD_DIR: begin
                matrix_rows[a][b] = 1'b1;
                pending_results.push_back(r);
            end
            abm_pkg::REQ_REMOVE: begin
                matrix_rows[a][b] = 1'b0;
                matrix_rows[b][a] = 1'b0;
                pending_results.push_back(r);
            end
            abm_pkg::REQ_TEST: begin
                r.edge_present = matrix_rows[a][b];
                pending_results.push_back(r);
            end
            abm_pkg::REQ_DEGREE: begin
                for (int c = 0; c < NODES; c++) begin
                    hits += row[c];
                end
                r.degree = abm_pkg::DEGREE_W'(hits);
                pending_results.push_back(r);
            end
            default: begin
                if (row == '0) begin
                    r.status = abm_pkg::ST_NO_NEIGHBOUR;
                    pending_results.push_back(r);
                end else begin
                    for (int c = 0; c < n && hits < abm_pkg::RESULT_CAP; c++) begin
                        if (row[c]) begin
                            r.neighbour = abm_pkg::NODE_W'(c);
                            r.last = ((row >> (c + 1)) == '0) ||
                                     (hits == abm_pkg::RESULT_CAP - 1);
                            pending_results.push_back(r);
                            hits++;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_request(input logic [abm_pkg::REQ_W-1:0] kind,
                                input logic [abm_pkg::NODE_W-1:0] a,
                                input logic [abm_pkg::NODE_W-1:0] b);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            idle_gap($urandom_range(1, IDLE_MAX));
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_req_type = kind;
        i_node_a   = a;
        i_node_b   = b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(kind, a, b);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic is_write,
                                input logic [abm_pkg::PADDR_W-1:0] addr,
                                input logic [abm_pkg::PDATA_W-1:0] data,
                                output logic [abm_pkg::PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    task automatic set_vertex_count(input logic [abm_pkg::VCOUNT_W-1:0] value);
        logic [abm_pkg::PDATA_W-1:0] readback;
        wait_drained();
        apb_transfer(1'b1, abm_pkg::ADDR_VCOUNT, abm_pkg::PDATA_W'(value), readback);
        vertex_count = value;
        reg_writes++;
        apb_transfer(1'b0, abm_pkg::ADDR_VCOUNT, '0, readback);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback[abm_pkg::VCOUNT_W-1:0] !== value) begin
            report_mismatch($sformatf("vertex_count read %0d, wrote %0d",
                                      readback[abm_pkg::VCOUNT_W-1:0], value));
        end
    endtask

    task automatic send_random_request();
        int                         n;
        int                         pick;
        logic [abm_pkg::REQ_W-1:0]  kind;
        logic [abm_pkg::NODE_W-1:0] a;
        logic [abm_pkg::NODE_W-1:0] b;
        n    = active_vertices();
        pick = $urandom_range(0, 99);
        if (pick < 5)       kind = ($urandom_range(0, 1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
        else if (pick < 30) kind = abm_pkg::REQ_ADD_UNDIR;
        else if (pick < 50) kind = abm_pkg::REQ_ADD_DIR;
        else if (pick < 62) kind = abm_pkg::REQ_REMOVE;
        else if (pick < 77) kind = abm_pkg::REQ_TEST;
        else if (pick < 87) kind = abm_pkg::REQ_DEGREE;
        else                kind = abm_pkg::REQ_LIST;
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            a = abm_pkg::NODE_W'($urandom_range(0, n - 1));
            b = abm_pkg::NODE_W'($urandom_range(0, n - 1));
        end else begin
            a = abm_pkg::NODE_W'($urandom_range(0, NODES - 1));
            b = abm_pkg::NODE_W'($urandom_range(0, NODES - 1));
        end
        send_request(kind, a, b);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                head = pending_results.pop_front();
                if (o_status !== head.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, head.status));
                if (o_edge_present !== head.edge_present)
                    report_mismatch($sformatf("edge_present %0d, expected %0d",
                                              o_edge_present, head.edge_present));
                if (o_degree !== head.degree)
                    report_mismatch($sformatf("degree %0d, expected %0d", o_degree, head.degree));
                if (o_neighbour !== head.neighbour)
                    report_mismatch($sformatf("neighbour %0d, expected %0d",
                                              o_neighbour, head.neighbour));
                if (o_last !== head.last)
                    report_mismatch($sformatf("last %0d, expected %0d", o_last, head.last));
            end
        end
    end

    task automatic test_basic_requests();
        send_request(abm_pkg::REQ_ADD_UNDIR, 4'd0, 4'd15);
        send_request(abm_pkg::REQ_TEST, 4'd0, 4'd15);
        send_request(abm_pkg::REQ_TEST, 4'd15, 4'd0);
        send_request(abm_pkg::REQ_TEST, 4'd1, 4'd2);
        send_request(abm_pkg::REQ_DEGREE, 4'd0, 4'd9);
        send_request(abm_pkg::REQ_LIST, 4'd0, 4'd3);
        // self loop set and cleared
        send_request(abm_pkg::REQ_ADD_DIR, 4'd3, 4'd3);
        send_request(abm_pkg::REQ_DEGREE, 4'd3, 4'd0);
        send_request(abm_pkg::REQ_LIST, 4'd3, 4'd15);
        send_request(abm_pkg::REQ_REMOVE, 4'd3, 4'd3);
        send_request(abm_pkg::REQ_TEST, 4'd3, 4'd3);
        send_request(abm_pkg::REQ_LIST, 4'd5, 4'd0);
        send_request(abm_pkg::REQ_ADD_DIR, 4'd15, 4'd0);
        send_request(abm_pkg::REQ_ADD_DIR, 4'd15, 4'd7);
        send_request(abm_pkg::REQ_LIST, 4'd15, 4'd15);
        send_request(abm_pkg::REQ_REMOVE, 4'd15, 4'd0);
        send_request(abm_pkg::REQ_LIST, 4'd15, 4'd0);
        send_request(abm_pkg::REQ_LIST, 4'd0, 4'd0);
        send_request(abm_pkg::REQ_DEGREE, 4'd0, 4'd15);
        send_request(REQ_UNUSED_6, 4'd15, 4'd15);
        send_request(REQ_UNUSED_7, 4'd0, 4'd0);
        send_request(abm_pkg::REQ_TEST, 4'd15, 4'd15);
    endtask

    task automatic test_long_listing();
        for (int c = 0; c < NODES; c++) begin
            send_request(abm_pkg::REQ_ADD_DIR, 4'd2, abm_pkg::NODE_W'(c));
        end
        send_request(abm_pkg::REQ_LIST, 4'd2, 4'd0);
        send_request(abm_pkg::REQ_DEGREE, 4'd2, 4'd0);
    endtask

    task automatic test_vertex_count();
        // no vertex in range at all
        set_vertex_count(5'd0);
        for (int k = 0; k <= int'(abm_pkg::REQ_LIST); k++) begin
            send_request(abm_pkg::REQ_W'(k), abm_pkg::NODE_W'($urandom_range(0, 15)),
                         abm_pkg::NODE_W'($urandom_range(0, 15)));
        end
        set_vertex_count(5'd1);
        send_request(abm_pkg::REQ_ADD_DIR, 4'd0, 4'd0);
        send_request(abm_pkg::REQ_TEST, 4'd0, 4'd1);
        send_request(abm_pkg::REQ_LIST, 4'd0, 4'd0);
        send_request(abm_pkg::REQ_DEGREE, 4'd1, 4'd0);
        // above the matrix size, saturates
        set_vertex_count(5'd31);
        send_request(abm_pkg::REQ_TEST, 4'd15, 4'd15);
        send_request(abm_pkg::REQ_DEGREE, 4'd2, 4'd0);
        // lowered count hides stored columns
        set_vertex_count(5'd4);
        send_request(abm_pkg::REQ_DEGREE, 4'd2, 4'd0);
        send_request(abm_pkg::REQ_LIST, 4'd2, 4'd0);
        send_request(abm_pkg::REQ_TEST, 4'd2, 4'd9);
        send_request(abm_pkg::REQ_LIST, 4'd0, 4'd0);
        set_vertex_count(5'd16);
        send_request(abm_pkg::REQ_DEGREE, 4'd2, 4'd0);
    endtask

    task automatic test_random_traffic();
        repeat (20) send_random_request();
        set_vertex_count(abm_pkg::VCOUNT_W'($urandom_range(1, 15)));
        repeat (15) send_random_request();
        set_vertex_count(5'd2);
        repeat (10) send_random_request();
        set_vertex_count(5'd16);
        idle_enable = 1'b0;
        repeat (18) send_random_request();
    endtask

    initial begin
        int waited;
        for (int r = 0; r < NODES; r++) begin
            matrix_rows[r] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_requests();
        test_long_listing();
        test_vertex_count();
        test_random_traffic();

        @(negedge i_clk);
        start  = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end

        $display("%0d requests sent, %0d results checked, %0d register writes",
                 requests_sent, results_seen, reg_writes);
        $display("vertex counts 0, 1, 2, 4, 16, 31 and one random value, %0d mismatches",
                 err_count);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout: run did not complete");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
